// File: rtl/tlsb_pkg.sv
// ----------------------------------------------------------------------------
// tlsb_pkg
// Types, codes and constants shared by the three-LED status blinker.
// ----------------------------------------------------------------------------
package tlsb_pkg;

  localparam int NUM_CH   = 3;
  localparam int TICK_MS  = 5;

  // Field widths of the item and result beats.
  localparam int DUR_W    = 19;
  localparam int PERIOD_W = 16;
  localparam int DUTY_W   = 9;
  localparam int COUNT_W  = 16;
  localparam int REM_W    = 16;

  // Tick length as a narrow constant, and the scaled phase width.
  localparam int TICK_W   = $clog2(TICK_MS + 1);
  localparam logic [TICK_W-1:0] TICK_VAL = TICK_W'(TICK_MS);
  localparam int SCALED_W = COUNT_W + TICK_W;

  // On-time limit is period times duty, held per channel.
  localparam int LIMIT_W  = PERIOD_W + DUTY_W;
  localparam int CMP_W    = SCALED_W + 8;

  // Division of the duration by the tick length uses a rounded-up reciprocal.
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS));
  localparam int QUOT_W      = DUR_W + RECIP_W - RECIP_SHIFT;

  // Item operations.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Blink modes.
  localparam logic [2:0] MODE_ALL   = 3'd0;
  localparam logic [2:0] MODE_ACCEL = 3'd1;
  localparam logic [2:0] MODE_MAG   = 3'd2;
  localparam logic [2:0] MODE_DARK  = 3'd3;

  typedef struct packed {
    logic                op;
    logic [1:0]          channel;
    logic [DUR_W-1:0]    duration_ms;
    logic [PERIOD_W-1:0] period_ms;
    logic [DUTY_W-1:0]   duty_q8;
    logic [COUNT_W-1:0]  start_count;
    logic                endless;
    logic [2:0]          blink_mode;
    logic [2:0]          accel_face;
    logic [1:0]          mag_step;
  } item_t;

  typedef struct packed {
    logic led0_level;
    logic led1_level;
    logic led2_level;
  } result_t;

  // Channels picked on an accelerometer calibration face.
  function automatic logic [NUM_CH-1:0] face_mask(input logic [2:0] face);
    logic [NUM_CH-1:0] m;
    case (face)
      3'd0:    m = 3'b001;
      3'd1:    m = 3'b010;
      3'd2:    m = 3'b011;
      3'd3:    m = 3'b100;
      3'd4:    m = 3'b101;
      3'd5:    m = 3'b110;
      default: m = 3'b111;
    endcase
    return m;
  endfunction

  // Channels picked on a magnetometer calibration step.
  function automatic logic [NUM_CH-1:0] step_mask(input logic [1:0] step);
    logic [NUM_CH-1:0] m;
    case (step)
      2'd0:    m = 3'b001;
      2'd1:    m = 3'b010;
      2'd2:    m = 3'b100;
      default: m = 3'b111;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/three_led_status_blinker_unit.sv
// ----------------------------------------------------------------------------
// three_led_status_blinker_unit
// Three active-low status LEDs with per-channel duration, period and duty.
// ----------------------------------------------------------------------------
// An accepted item is held in the input register and then in the result register.
// Throughput: one item per cycle while result beats are taken; the input register
// and the result register let a new item enter while a finished result waits to be taken.
// Reset clears all channel settings and counters and sets every channel's pin level dark.
module three_led_status_blinker_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  tlsb_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output tlsb_pkg::result_t result
);
  import tlsb_pkg::*;

  // Input register.
  logic  a_valid;
  item_t a_item;
  logic  advance;

  // Channel state.
  logic [REM_W-1:0]    rem        [NUM_CH];
  logic [PERIOD_W-1:0] period     [NUM_CH];
  logic [LIMIT_W-1:0]  on_limit   [NUM_CH];
  logic [COUNT_W-1:0]  phase      [NUM_CH];
  logic [NUM_CH-1:0]   endless_st;
  logic [NUM_CH-1:0]   pin_level;

  logic [REM_W-1:0]    rem_next   [NUM_CH];
  logic [PERIOD_W-1:0] period_next[NUM_CH];
  logic [LIMIT_W-1:0]  on_limit_next[NUM_CH];
  logic [COUNT_W-1:0]  phase_next [NUM_CH];
  logic [NUM_CH-1:0]   endless_st_next;
  logic [NUM_CH-1:0]   pin_level_next;

  // Per-channel tick candidates.
  logic [REM_W-1:0]    rem_dec    [NUM_CH];
  logic [COUNT_W-1:0]  phase_adv  [NUM_CH];
  logic [NUM_CH-1:0]   pin_adv;

  // Load-side arithmetic.
  logic [DUR_W+RECIP_W-1:0] dur_prod;
  logic [QUOT_W-1:0]        dur_quot;
  logic [REM_W-1:0]         load_ticks;
  logic [LIMIT_W-1:0]       load_limit;

  logic [NUM_CH-1:0] tick_mask;

  assign advance    = a_valid && (!result_valid || result_ready);
  assign item_ready = !a_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (item_ready) begin
      a_valid <= item_valid;
    end
    if (item_ready && item_valid) begin
      a_item <= item;
    end
  end

  // Duration over tick length by reciprocal multiply, saturated to 16 bits.
  assign dur_prod   = (DUR_W+RECIP_W)'(a_item.duration_ms) * (DUR_W+RECIP_W)'(RECIP);
  assign dur_quot   = dur_prod[DUR_W+RECIP_W-1:RECIP_SHIFT];
  assign load_ticks = (dur_quot > QUOT_W'({REM_W{1'b1}})) ? {REM_W{1'b1}}
                                                          : dur_quot[REM_W-1:0];
  assign load_limit = LIMIT_W'(a_item.period_ms) * LIMIT_W'(a_item.duty_q8);

  for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
    logic                run;
    logic [COUNT_W-1:0]  cnt_inc;
    logic [SCALED_W-1:0] scaled_inc;
    logic                wrap;
    logic [SCALED_W-1:0] scaled_new;
    logic                lit;

    assign rem_dec[g]  = (rem[g] != '0) ? rem[g] - REM_W'(1) : rem[g];
    assign run         = (rem_dec[g] != '0) || endless_st[g];
    assign cnt_inc     = phase[g] + COUNT_W'(1);
    assign scaled_inc  = SCALED_W'(cnt_inc) * SCALED_W'(TICK_VAL);
    assign wrap        = scaled_inc >= SCALED_W'(period[g]);
    assign scaled_new  = wrap ? '0 : scaled_inc;
    assign lit         = {scaled_new, 8'd0} <= CMP_W'(on_limit[g]);
    assign phase_adv[g] = !run ? phase[g] : (wrap ? '0 : cnt_inc);
    // A channel whose time has just run out keeps its level; one already at
    // zero goes dark.
    assign pin_adv[g]  = run ? !lit : ((rem[g] == '0) ? 1'b1 : pin_level[g]);
  end

  always_comb begin
    case (a_item.blink_mode)
      MODE_ALL:   tick_mask = '1;
      MODE_ACCEL: tick_mask = face_mask(a_item.accel_face);
      MODE_MAG:   tick_mask = step_mask(a_item.mag_step);
      default:    tick_mask = '0;
    endcase
  end

  always_comb begin
    rem_next        = rem;
    period_next     = period;
    on_limit_next   = on_limit;
    phase_next      = phase;
    endless_st_next = endless_st;
    pin_level_next  = pin_level;
    if (advance) begin
      if (a_item.op == OP_LOAD) begin
        for (int c = 0; c < NUM_CH; c++) begin
          if (a_item.channel == 2'(c)) begin
            rem_next[c]        = load_ticks;
            period_next[c]     = a_item.period_ms;
            on_limit_next[c]   = load_limit;
            phase_next[c]      = a_item.start_count;
            endless_st_next[c] = a_item.endless;
          end
        end
      end else if (a_item.blink_mode == MODE_DARK) begin
        pin_level_next = '1;
      end else if (a_item.blink_mode == MODE_ALL || a_item.blink_mode == MODE_ACCEL ||
                   a_item.blink_mode == MODE_MAG) begin
        for (int c = 0; c < NUM_CH; c++) begin
          if (tick_mask[c]) begin
            rem_next[c]       = rem_dec[c];
            phase_next[c]     = phase_adv[c];
            pin_level_next[c] = pin_adv[c];
          end else begin
            pin_level_next[c] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CH; c++) begin
        rem[c]      <= '0;
        period[c]   <= '0;
        on_limit[c] <= '0;
        phase[c]    <= '0;
      end
      endless_st <= '0;
      pin_level  <= '1;
    end else begin
      rem        <= rem_next;
      period     <= period_next;
      on_limit   <= on_limit_next;
      phase      <= phase_next;
      endless_st <= endless_st_next;
      pin_level  <= pin_level_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (advance) begin
      result.led0_level <= pin_level_next[0];
      result.led1_level <= pin_level_next[1];
      result.led2_level <= pin_level_next[2];
    end
  end

`ifndef SYNTHESIS
  a_advance_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("accepted item did not produce a result beat");

  a_dark_mode: assert property (@(posedge clk) disable iff (rst)
    advance && a_item.op == OP_TICK && a_item.blink_mode == MODE_DARK |=>
      result.led0_level && result.led1_level && result.led2_level)
    else $error("all-dark mode left an LED lit");

  a_load_holds_levels: assert property (@(posedge clk) disable iff (rst)
    advance && a_item.op == OP_LOAD |=>
      result.led0_level == $past(pin_level[0]) &&
      result.led1_level == $past(pin_level[1]) &&
      result.led2_level == $past(pin_level[2]))
    else $error("load item changed the LED levels");

  a_rem_only_falls: assert property (@(posedge clk) disable iff (rst)
    !(advance && a_item.op == OP_LOAD) |=>
      rem[0] <= $past(rem[0]) && rem[1] <= $past(rem[1]) && rem[2] <= $past(rem[2]))
    else $error("remaining time rose without a load");
`endif

endmodule

// File: tb/sv/three_led_status_blinker_unit_tb.sv
// ----------------------------------------------------------------------------
// three_led_status_blinker_unit_tb
// Self-checking bench for the three-LED status blinker. Load and tick beats
// are sent with random gaps while the result side stalls at random, but for a
// steady phase with neither. A behavioural copy of the channel state predicts
// the three pin levels per accepted beat, compared in order with each result.
// ----------------------------------------------------------------------------
module three_led_status_blinker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tlsb_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  three_led_status_blinker_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted channel state.
  logic [REM_W-1:0]    rem_ticks [NUM_CH];
  logic [PERIOD_W-1:0] period_q  [NUM_CH];
  logic [DUTY_W-1:0]   duty_q    [NUM_CH];
  logic [COUNT_W-1:0]  phase_q   [NUM_CH];
  logic                endless_q [NUM_CH];
  logic                pin_q     [NUM_CH];

  result_t expected_levels[$];
  result_t want_levels;
  int      fail_count = 0;
  int      mismatch_count = 0;
  int      idle_cycles = 0;
  int      ready_hold = 0;
  bit      no_idle = 1'b0;

  // One tick of a single channel: count down, then step the phase and
  // compare it against the on-time of the period.
  function automatic void advance_led(input int c);
    logic [COUNT_W-1:0] ph;
    longint unsigned    on_lhs;
    longint unsigned    on_rhs;
    if (rem_ticks[c] != '0) begin
      rem_ticks[c] = rem_ticks[c] - 1'b1;
    end else begin
      pin_q[c] = 1'b1;
    end
    if (rem_ticks[c] != '0 || endless_q[c]) begin
      ph = phase_q[c] + 1'b1;
      if (64'(TICK_MS) * 64'(ph) >= 64'(period_q[c])) begin
        ph = '0;
      end
      phase_q[c] = ph;
      on_lhs = 64'd256 * 64'(TICK_MS) * 64'(ph);
      on_rhs = 64'(period_q[c]) * 64'(duty_q[c]);
      pin_q[c] = (on_lhs <= on_rhs) ? 1'b0 : 1'b1;
    end
  endfunction

  function automatic result_t blinker_next_levels(input item_t it);
    logic [NUM_CH-1:0] pick;
    longint unsigned   ticks;
    bit                run_pick;
    result_t           r;
    run_pick = 1'b0;
    pick = '0;
    if (it.op == OP_LOAD) begin
      if (int'(it.channel) < NUM_CH) begin
        ticks = 64'(it.duration_ms) / 64'(TICK_MS);
        if (ticks > 64'hFFFF) begin
          ticks = 64'hFFFF;
        end
        rem_ticks[it.channel] = ticks[REM_W-1:0];
        period_q[it.channel]  = it.period_ms;
        duty_q[it.channel]    = it.duty_q8;
        phase_q[it.channel]   = it.start_count;
        endless_q[it.channel] = it.endless;
      end
    end else begin
      case (it.blink_mode)
        MODE_ALL: begin
          pick = '1;
          run_pick = 1'b1;
        end
        MODE_ACCEL: begin
          pick = (it.accel_face > 3'd5) ? 3'b111 : it.accel_face + 3'd1;
          run_pick = 1'b1;
        end
        MODE_MAG: begin
          pick = (it.mag_step == 2'd3) ? 3'b111 : 3'b001 << it.mag_step;
          run_pick = 1'b1;
        end
        MODE_DARK: begin
          for (int c = 0; c < NUM_CH; c++) pin_q[c] = 1'b1;
        end
        default: begin
          // Unknown modes leave every pin as it is.
        end
      endcase
      if (run_pick) begin
        for (int c = 0; c < NUM_CH; c++) begin
          if (pick[c]) begin
            advance_led(c);
          end else begin
            pin_q[c] = 1'b1;
          end
        end
      end
    end
    r.led0_level = pin_q[0];
    r.led1_level = pin_q[1];
    r.led2_level = pin_q[2];
    return r;
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic item_t make_load(input logic [1:0] ch, input int dur, input int per,
                                      input int duty, input int start, input logic forever_on);
    item_t it;
    it = '0;
    it.op          = OP_LOAD;
    it.channel     = ch;
    it.duration_ms = DUR_W'(dur);
    it.period_ms   = PERIOD_W'(per);
    it.duty_q8     = DUTY_W'(duty);
    it.start_count = COUNT_W'(start);
    it.endless     = forever_on;
    return it;
  endfunction

  function automatic item_t make_tick(input logic [2:0] mode, input logic [2:0] face,
                                      input logic [1:0] mstep);
    item_t it;
    it = '0;
    it.op         = OP_TICK;
    it.blink_mode = mode;
    it.accel_face = face;
    it.mag_step   = mstep;
    return it;
  endfunction

  // Unused fields carry random content so that every bit toggles.
  function automatic item_t random_item();
    item_t it;
    int    r;
    it.channel     = 2'($urandom);
    it.duration_ms = DUR_W'($urandom);
    it.period_ms   = PERIOD_W'($urandom);
    it.duty_q8     = DUTY_W'($urandom);
    it.start_count = COUNT_W'($urandom);
    it.endless     = 1'($urandom);
    it.blink_mode  = 3'($urandom);
    it.accel_face  = 3'($urandom);
    it.mag_step    = 2'($urandom);
    if ($urandom_range(0, 99) < 15) begin
      it.op = OP_LOAD;
      if ($urandom_range(0, 99) >= 8) it.channel = 2'($urandom_range(0, NUM_CH - 1));
      r = $urandom_range(0, 99);
      if (r < 70) it.duration_ms = DUR_W'($urandom_range(0, 300));
      else if (r < 90) it.duration_ms = DUR_W'($urandom_range(0, 327675));
      r = $urandom_range(0, 99);
      if (r < 10) it.period_ms = '0;
      else if (r < 70) it.period_ms = PERIOD_W'($urandom_range(0, 120));
      if ($urandom_range(0, 99) < 70) it.duty_q8 = DUTY_W'($urandom_range(0, 256));
      if ($urandom_range(0, 99) < 70) it.start_count = COUNT_W'($urandom_range(0, 30));
    end else begin
      it.op = OP_TICK;
      r = $urandom_range(0, 99);
      if (r < 50) it.blink_mode = MODE_ALL;
      else if (r < 65) it.blink_mode = MODE_ACCEL;
      else if (r < 80) it.blink_mode = MODE_MAG;
      else if (r < 88) it.blink_mode = MODE_DARK;
      else it.blink_mode = 3'($urandom_range(4, 7));
    end
    return it;
  endfunction

  // Offer one beat and hold it until taken; the expectation is recorded at
  // the edge of acceptance.
  task automatic send_item(input item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    expected_levels.push_back(blinker_next_levels(it));
  endtask

  task automatic test_idle_dark();
    send_item(make_tick(MODE_ALL, 3'd0, 2'd0));
    send_item(make_tick(MODE_DARK, 3'd7, 2'd3));
  endtask

  // Extremes of the load fields, the ignored fourth channel, a duration
  // that saturates, duty above full scale and a zero period.
  task automatic test_load_extremes();
    send_item(make_load(2'd0, 524287, 65535, 511, 65535, 1'b1));
    send_item(make_load(2'd1, 0, 0, 0, 0, 1'b1));
    send_item(make_load(2'd2, 10, 20, 128, 0, 1'b0));
    send_item(make_load(2'd3, 524287, 65535, 511, 65535, 1'b1));
    repeat (3) send_item(make_tick(MODE_ALL, 3'd0, 2'd0));
  endtask

  task automatic test_selection();
    for (int f = 0; f < 8; f++) send_item(make_tick(MODE_ACCEL, 3'(f), 2'd0));
    for (int s = 0; s < 4; s++) send_item(make_tick(MODE_MAG, 3'd0, 2'(s)));
    send_item(make_tick(MODE_DARK, 3'd0, 2'd0));
    send_item(make_tick(3'd4, 3'd0, 2'd0));
    send_item(make_tick(3'd7, 3'd0, 2'd0));
  endtask

  task automatic test_random_traffic(input int count, input bit steady);
    no_idle = steady;
    repeat (count) send_item(random_item());
    no_idle = 1'b0;
  endtask

  // Result side: ready runs high or low for random stretches, and stays high while no_idle is set.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      ready_hold   <= 0;
    end else if (no_idle) begin
      result_ready <= 1'b1;
      ready_hold   <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!result_ready) begin
      result_ready <= 1'b1;
      ready_hold   <= $urandom_range(0, 15);
    end else begin
      result_ready <= 1'b0;
      ready_hold   <= ($urandom_range(0, 99) < 80) ? $urandom_range(0, 2)
                                                   : $urandom_range(8, 40);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_levels.size() == 0) begin
        fail_count++;
        if (mismatch_count < 10) begin
          $display("%0t: unexpected result beat, levels %b%b%b", $realtime,
                   result.led0_level, result.led1_level, result.led2_level);
        end
        mismatch_count++;
      end else begin
        want_levels = expected_levels.pop_front();
        if (result.led0_level !== want_levels.led0_level ||
            result.led1_level !== want_levels.led1_level ||
            result.led2_level !== want_levels.led2_level) begin
          fail_count++;
          if (mismatch_count < 10) begin
            $display("%0t: led levels expected %b%b%b, got %b%b%b", $realtime,
                     want_levels.led0_level, want_levels.led1_level,
                     want_levels.led2_level, result.led0_level,
                     result.led1_level, result.led2_level);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Stall detector: too long without any beat on either side.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $realtime, idle_cycles);
        $display("** three_led_status_blinker_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    for (int c = 0; c < NUM_CH; c++) begin
      rem_ticks[c] = '0;
      period_q[c]  = '0;
      duty_q[c]    = '0;
      phase_q[c]   = '0;
      endless_q[c] = 1'b0;
      pin_q[c]     = 1'b1;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_dark();
    test_load_extremes();
    test_selection();
    test_random_traffic(350, 1'b0);
    test_random_traffic(250, 1'b1);
    test_random_traffic(400, 1'b0);

    item_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && expected_levels.size() == 0) begin
      $display("** three_led_status_blinker_unit: PASSED **");
    end else begin
      $display("** three_led_status_blinker_unit: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tlsb_pkg.sv
rtl/three_led_status_blinker_unit.sv
tb/sv/three_led_status_blinker_unit_tb.sv
